### sv/bcq_pkg.sv
// Shared types and constants for the bounded circular queue.
// No dependencies; imported by the ring store, the top level, the checker and the testbench top.
package bcq_pkg;

   // Width of one stored value
   localparam int DATA_W = 32;
   // Width of the capacity register and of the reported occupancy
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;
   // Capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Operation codes carried by an input transfer
   typedef enum logic [1:0] {
      FUNC_ENQ  = 2'd0,
      FUNC_DEQ  = 2'd1,
      FUNC_DISP = 2'd2,
      FUNC_PEEK = 2'd3
   } func_type;

   // Status codes carried by a result transfer
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

endpackage

### sv/bcq_ring_ram.sv
// Ring store of the queue: one write port, two read ports, registered reads.
// Depends on bcq_pkg for the data width.
module bcq_ring_ram
   import bcq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read two entries; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sv/bounded_circular_queue_top.sv
// Bounded circular queue: controller and output register around the ring store.
// Depends on bcq_pkg and bcq_ring_ram.
//
//  channel | ports                                 | direction | handshake
//  --------+---------------------------------------+-----------+------------
//  req     | req_func, req_value                   | in        | valid/stall
//  rsp     | rsp_status, rsp_front_value,          | out       | valid/stall
//          | rsp_rear_value, rsp_occupancy, rsp_last|          |
//  csr     | csr_capacity                          | in        | valid/ready
//
// Enqueue and every empty or full case are answered straight from the idle state.
// Dequeue and peek pass through the read state for the registered store read.
// Display does one store read and then one output load for each value.
// Reset (synchronous) empties the queue and sets the capacity to 16; store
// contents are left as they are. A stalled result holds the controller, and
// req_stall stays high until the output register can take the next result.
module bounded_circular_queue_top
   import bcq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // input channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_front_value,
   output logic signed [DATA_W-1:0] rsp_rear_value,
   output logic [OCC_W-1:0]         rsp_occupancy,
   output logic                     rsp_last,
   // capacity register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_capacity
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DREQ,
      ST_DOUT
   } state_type;

   state_type           state_ff, state_in;
   func_type            func_ff, func_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_front_ff, rsp_front_in;
   logic [DATA_W-1:0]   rsp_rear_ff, rsp_rear_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic                accept;
   logic                full;
   logic                empty;
   logic [LW-1:0]       cap_ext;
   logic [LW-1:0]       lim;
   logic [AW-1:0]       rear_idx;
   func_type            req_op;

   logic                wr_en;
   logic                rd_en;
   logic [AW-1:0]       rd_addr_a;
   logic [DATA_W-1:0]   rd_data_a;
   logic [DATA_W-1:0]   rd_data_b;

   // Advance a ring position with wrap at DEPTH
   function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
      next_pos = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   // Handshake decode
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign req_op    = func_type'(req_func);

   // Clamp the capacity to 1..DEPTH
   assign cap_ext = LW'(cap_ff);
   always_comb begin
      if (cap_ext == '0) begin
         lim = LW'(1);
      end else if (cap_ext > LW'(DEPTH)) begin
         lim = LW'(DEPTH);
      end else begin
         lim = cap_ext;
      end
   end

   assign full     = LW'(count_ff) >= lim;
   assign empty    = count_ff == '0;
   assign rear_idx = (tail_ff == '0) ? AW'(DEPTH - 1) : tail_ff - AW'(1);
   assign rd_addr_a = (state_ff == ST_IDLE) ? head_ff : ptr_ff;

   // Next-state and output register logic
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_rear_in   = rsp_rear_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      // Take a capacity write
      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in = req_op;
               unique case (req_op)
                  FUNC_ENQ: begin
                     rsp_valid_in = 1'b1;
                     rsp_front_in = '0;
                     rsp_rear_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                        rsp_occ_in    = OCC_W'(count_ff);
                     end else begin
                        wr_en         = 1'b1;
                        tail_in       = next_pos(tail_ff);
                        count_in      = count_ff + CW'(1);
                        rsp_status_in = STAT_OK;
                        rsp_occ_in    = OCC_W'(count_ff + CW'(1));
                     end
                  end
                  FUNC_DEQ, FUNC_PEEK: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_front_in  = '0;
                        rsp_rear_in   = '0;
                        rsp_occ_in    = OCC_W'(count_ff);
                        rsp_last_in   = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                        if (req_op == FUNC_DEQ) begin
                           head_in  = next_pos(head_ff);
                           count_in = count_ff - CW'(1);
                        end
                     end
                  end
                  FUNC_DISP: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_front_in  = '0;
                        rsp_rear_in   = '0;
                        rsp_occ_in    = OCC_W'(count_ff);
                        rsp_last_in   = 1'b1;
                     end else begin
                        ptr_in   = head_ff;
                        rem_in   = count_ff;
                        state_in = ST_DREQ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            // Load the dequeued or peeked values once the output is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_front_in  = rd_data_a;
               rsp_rear_in   = (func_ff == FUNC_PEEK) ? rd_data_b : '0;
               rsp_occ_in    = OCC_W'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DREQ: begin
            // Fetch the next displayed value
            rd_en    = 1'b1;
            ptr_in   = next_pos(ptr_ff);
            rem_in   = rem_ff - CW'(1);
            state_in = ST_DOUT;
         end
         ST_DOUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_front_in  = rd_data_a;
               rsp_rear_in   = '0;
               rsp_occ_in    = OCC_W'(count_ff);
               rsp_last_in   = rem_ff == '0;
               state_in      = (rem_ff == '0) ? ST_IDLE : ST_DREQ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state, work registers and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_rear_ff   <= rsp_rear_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   bcq_ring_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (tail_ff),
      .wr_data   (req_value),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rear_idx),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_front_value = $signed(rsp_front_ff);
   assign rsp_rear_value  = $signed(rsp_rear_ff);
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### tb/bcq_queue_checker.sv
// Checker for the bounded circular queue: watches the request, result and
// capacity channels, keeps a mirror of the queue and compares every result.
// Depends on bcq_pkg.
module bcq_queue_checker
   import bcq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [1:0]               rsp_status,
   input  logic signed [DATA_W-1:0] rsp_front_value,
   input  logic signed [DATA_W-1:0] rsp_rear_value,
   input  logic [OCC_W-1:0]         rsp_occupancy,
   input  logic                     rsp_last,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_capacity,
   output int                       outstanding,
   output int                       failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] front;
      logic [DATA_W-1:0] rear;
      logic [OCC_W-1:0]  occ;
      logic              last;
   } answer_type;

   // Mirror of the queue contents and the capacity register
   logic [DATA_W-1:0] mirror_ring [DEPTH];
   int                mirror_head;
   int                mirror_tail;
   int                mirror_count;
   logic [CAP_W-1:0]  mirror_cap;

   // Results the queue still owes, oldest first
   answer_type answer_fifo [$];

   function automatic int next_slot(int p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   // Apply one operation to the mirror and queue up the results it causes
   function automatic void apply_queue_op(func_type op, logic [DATA_W-1:0] val);
      int         lim;
      int         p;
      answer_type a;
      lim = int'(mirror_cap);
      if (lim == 0) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      a = '{status: STAT_OK, front: '0, rear: '0, occ: '0, last: 1'b1};
      // Anything but enqueue on an empty queue gives one empty status
      if (op != FUNC_ENQ && mirror_count == 0) begin
         a.status = STAT_EMPTY;
         answer_fifo.push_back(a);
         return;
      end
      case (op)
         FUNC_ENQ: begin
            if (mirror_count >= lim) begin
               a.status = STAT_FULL;
            end else begin
               mirror_ring[mirror_tail] = val;
               mirror_tail = next_slot(mirror_tail);
               mirror_count++;
            end
         end
         FUNC_DEQ: begin
            a.front = mirror_ring[mirror_head];
            mirror_head = next_slot(mirror_head);
            mirror_count--;
         end
         FUNC_PEEK: begin
            a.front = mirror_ring[mirror_head];
            a.rear = mirror_ring[(mirror_tail == 0) ? DEPTH - 1 : mirror_tail - 1];
         end
         default: begin
            // Display: one result per stored value, front to rear
            p = mirror_head;
            for (int i = 0; i < mirror_count; i++) begin
               a.front = mirror_ring[p];
               a.occ = OCC_W'(mirror_count);
               a.last = (i == mirror_count - 1);
               answer_fifo.push_back(a);
               p = next_slot(p);
            end
            return;
         end
      endcase
      a.occ = OCC_W'(mirror_count);
      answer_fifo.push_back(a);
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         failures++;
      end
   endfunction

   // Track every transfer; compare results before taking new requests, and
   // let a capacity write count only from the next request on
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         mirror_head = 0;
         mirror_tail = 0;
         mirror_count = 0;
         mirror_cap = CAP_RESET;
         answer_fifo.delete();
         failures = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answer_fifo.size() == 0) begin
               $error("result transfer with no result pending (status %0d)", rsp_status);
               failures++;
            end else begin
               want = answer_fifo.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("front_value", want.front, rsp_front_value);
               check_field("rear_value", want.rear, rsp_rear_value);
               check_field("occupancy", 32'(want.occ), 32'(rsp_occupancy));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall) apply_queue_op(func_type'(req_func), req_value);
         if (csr_valid && csr_ready) mirror_cap = csr_capacity;
      end
      outstanding = answer_fifo.size();
   end

endmodule

### tb/tb_top.sv
// Top of the bounded circular queue testbench: clock, reset, request and
// capacity stimulus, result back-pressure and the final verdict.
// Depends on bcq_pkg, bounded_circular_queue_top and bcq_queue_checker.
module tb_top;
   import bcq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 60;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_func;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_front_value;
   logic signed [DATA_W-1:0] rsp_rear_value;
   logic [OCC_W-1:0]         rsp_occupancy;
   logic                     rsp_last;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_capacity;

   int outstanding;
   int failures;

   // Knobs for the request and result drivers
   bit tx_gaps;
   bit rx_quiet;
   int hold_req;

   bounded_circular_queue_top #(.DEPTH(DEPTH)) dut (.*);

   bcq_queue_checker #(.DEPTH(DEPTH)) queue_chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result back-pressure: short random bursts, or one long hold on request
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            n = hold_req;
            hold_req = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!rx_quiet && !reset && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request and hold it until the transfer; called at a clock edge
   task automatic push_item(input func_type op, input logic [DATA_W-1:0] val);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= op;
      req_value <= val;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every pending result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_valid <= 1'b1;
      csr_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CAP_W-1:0] caps [PHASES];
      int               enq_pct;
      int               r;
      func_type         op;

      caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd0};
      caps[PHASES-1] = CAP_W'($urandom_range(0, 31));
      req_valid <= 1'b0;
      req_func <= FUNC_ENQ;
      req_value <= '0;
      csr_valid <= 1'b0;
      csr_capacity <= '0;
      reset <= 1'b1;
      tx_gaps = 1'b1;
      rx_quiet = 1'b0;
      hold_req = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty queue, value extremes, peek and display at reset capacity
      push_item(FUNC_PEEK, 32'h1234_5678);
      push_item(FUNC_DEQ, '1);
      push_item(FUNC_DISP, '0);
      push_item(FUNC_ENQ, 32'h7FFF_FFFF);
      push_item(FUNC_ENQ, 32'h8000_0000);
      push_item(FUNC_ENQ, 32'h0000_0000);
      push_item(FUNC_ENQ, 32'hFFFF_FFFF);
      push_item(FUNC_PEEK, '0);
      push_item(FUNC_DISP, '0);
      push_item(FUNC_DEQ, '0);
      push_item(FUNC_ENQ, 32'h5555_5555);
      push_item(FUNC_ENQ, 32'hAAAA_AAAA);
      push_item(FUNC_DISP, '0);

      // Lower the capacity below the occupancy: nothing lost, enqueue full
      wait_drained();
      write_capacity(5'd3);
      push_item(FUNC_ENQ, 32'h0BAD_CAFE);
      push_item(FUNC_DEQ, '0);
      push_item(FUNC_DEQ, '0);
      push_item(FUNC_ENQ, 32'h0F0F_0F0F);
      push_item(FUNC_DEQ, '0);
      push_item(FUNC_ENQ, 32'hF0F0_F0F0);
      push_item(FUNC_ENQ, 32'h1357_9BDF);
      push_item(FUNC_PEEK, '0);

      // Capacity zero acts as one
      wait_drained();
      write_capacity(5'd0);
      repeat (3) push_item(FUNC_DEQ, '0);
      push_item(FUNC_ENQ, 32'h2468_ACE0);
      push_item(FUNC_ENQ, 32'h3141_5926);

      // Random phases, each under its own capacity
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         write_capacity(caps[ph]);
         if (ph == 2) hold_req = 80;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // Switch between filling and draining, and request gaps and result stalls on or off
            if (i % 15 == 0) begin
               enq_pct = $urandom_range(0, 1) ? 75 : 30;
               tx_gaps = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
               rx_quiet = (ph >= PHASES - 2) || ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < enq_pct) begin
               op = FUNC_ENQ;
            end else begin
               r = $urandom_range(0, 19);
               op = (r < 11) ? FUNC_DEQ : (r < 15) ? FUNC_PEEK : FUNC_DISP;
            end
            push_item(op, $urandom);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
